/* rtl/core/bpwq_pkg.sv */
package bpwq_pkg;

    localparam int POOL_DEPTH = 16;
    localparam int WAIT_DEPTH = 16;
    localparam int PIDX_W     = $clog2(POOL_DEPTH);
    localparam int WIDX_W     = $clog2(WAIT_DEPTH);
    localparam int CNT_W      = 5;
    localparam int REQ_W      = 8;
    localparam int EV_W       = 3;

    typedef enum logic [EV_W-1:0] {
        EV_GRANT   = 3'd0,
        EV_QUEUED  = 3'd1,
        EV_HANDOFF = 3'd2,
        EV_FREED   = 3'd3,
        EV_FULL    = 3'd4
    } t_event;

    typedef struct packed {
        logic              req_type;
        logic [REQ_W-1:0]  requester_id;
        logic [PIDX_W-1:0] entry_index;
    } t_in_word;

    typedef struct packed {
        logic [EV_W-1:0]   event_res;
        logic [REQ_W-1:0]  grant_requester;
        logic [PIDX_W-1:0] grant_entry;
        logic [CNT_W-1:0]  busy_entries;
        logic              pool_busy;
        logic [CNT_W-1:0]  waiter_count;
    } t_out_word;

    // Control bundle for the free-list store.
    typedef struct packed {
        logic              clear;
        logic              wr_en;
        logic [PIDX_W-1:0] wr_addr;
        logic [PIDX_W-1:0] wr_data;
        logic [PIDX_W-1:0] rd_addr;
    } t_free_ctl;

endpackage

/* rtl/core/bpwq_ram.sv */
module bpwq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/core/bpwq_free_list.sv */
module bpwq_free_list
    import bpwq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_free_ctl         i_ctl,
    output logic [PIDX_W-1:0] o_rd_data
);

    logic [POOL_DEPTH-1:0] r_valid;
    logic                  r_rd_valid;
    logic [PIDX_W-1:0]     r_rd_idx;
    logic [PIDX_W-1:0]     ram_q;

    bpwq_ram #(
        .WIDTH (PIDX_W),
        .DEPTH (POOL_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_ctl.wr_en),
        .i_wr_addr (i_ctl.wr_addr),
        .i_wr_data (i_ctl.wr_data),
        .i_rd_addr (i_ctl.rd_addr),
        .o_rd_data (ram_q)
    );

    // Unwritten slots read as their own index (refill order).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_valid <= '0;
        end else if (i_ctl.wr_en) begin
            r_valid[i_ctl.wr_addr] <= 1'b1;
        end
        r_rd_valid <= r_valid[i_ctl.rd_addr];
        r_rd_idx   <= i_ctl.rd_addr;
    end

    assign o_rd_data = r_rd_valid ? ram_q : r_rd_idx;

endmodule

/* rtl/core/buffer_pool_with_wait_queue_core.sv */
// Channel | Direction | Handshake          | Word
// in      | input     | i_in_valid/o_in_stall   | t_in_word (request)
// out     | output    | o_out_valid/i_out_stall | t_out_word (result)
// cfg     | input     | i_cfg_valid/o_cfg_ready | capacity, 5 bits
//
// A request is taken in ST_IDLE, where the accept edge reads both stores at their
// head pointers; the edge that leaves ST_EXEC applies the update and loads the result.
// The registered read of the free-list and wait-queue RAMs sets this split.
// The result register holds while stalled; the next request is accepted meanwhile.
// Reset (synchronous, active low) and a capacity write both refill the pool.
module buffer_pool_with_wait_queue_core
    import bpwq_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_word         i_in_word,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_word        o_out_word,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CNT_W-1:0] i_cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } t_state;

    t_state            r_state, n_state;
    t_in_word          r_item;
    t_out_word         r_out, n_out;
    logic              r_out_valid;

    logic [PIDX_W-1:0] r_free_head, n_free_head;
    logic [CNT_W-1:0]  r_free_count, n_free_count;
    logic [WIDX_W-1:0] r_wait_head, n_wait_head;
    logic [WIDX_W-1:0] r_wait_tail, n_wait_tail;
    logic [CNT_W-1:0]  r_waiters, n_waiters;
    logic [CNT_W-1:0]  r_busy, n_busy;

    t_free_ctl         free_ctl;
    logic [PIDX_W-1:0] free_rd;
    logic [REQ_W-1:0]  wait_rd;
    logic              wait_wr_en;

    logic              in_take;
    logic              exec_go;
    logic              cfg_take;
    logic [CNT_W-1:0]  cfg_size;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_take     = i_in_valid && (r_state == ST_IDLE);
    // Finish only when the result register is free or drains this cycle.
    assign exec_go     = (r_state == ST_EXEC) && (!r_out_valid || !i_out_stall);
    assign o_cfg_ready = 1'b1;
    assign cfg_take    = i_cfg_valid;

    // Clamp the size into 1..POOL_DEPTH.
    always_comb begin
        if (i_cfg_data == '0) begin
            cfg_size = CNT_W'(1);
        end else if (i_cfg_data > CNT_W'(POOL_DEPTH)) begin
            cfg_size = CNT_W'(POOL_DEPTH);
        end else begin
            cfg_size = i_cfg_data;
        end
    end

    // Request update: read data arrived from the accept edge.
    always_comb begin
        n_free_head  = r_free_head;
        n_free_count = r_free_count;
        n_wait_head  = r_wait_head;
        n_wait_tail  = r_wait_tail;
        n_waiters    = r_waiters;
        n_busy       = r_busy;
        wait_wr_en   = 1'b0;
        free_ctl     = '0;
        n_out        = '0;

        free_ctl.clear   = cfg_take;
        free_ctl.rd_addr = r_free_head;
        free_ctl.wr_addr = r_free_head + r_free_count[PIDX_W-1:0];
        free_ctl.wr_data = r_item.entry_index;

        if (!r_item.req_type) begin
            if (r_free_count != '0) begin
                // Grant the oldest free entry.
                n_out.event_res       = EV_GRANT;
                n_out.grant_entry     = free_rd;
                n_out.grant_requester = r_item.requester_id;
                n_free_head           = r_free_head + PIDX_W'(1);
                n_free_count          = r_free_count - CNT_W'(1);
                n_busy                = r_busy + CNT_W'(1);
            end else if (r_waiters < CNT_W'(WAIT_DEPTH)) begin
                // Park the requester at the queue tail.
                n_out.event_res = EV_QUEUED;
                wait_wr_en      = exec_go;
                n_wait_tail     = r_wait_tail + WIDX_W'(1);
                n_waiters       = r_waiters + CNT_W'(1);
            end else begin
                n_out.event_res = EV_FULL;
            end
        end else begin
            if (r_waiters != '0) begin
                // Hand the entry straight to the oldest waiter.
                n_out.event_res       = EV_HANDOFF;
                n_out.grant_entry     = r_item.entry_index;
                n_out.grant_requester = wait_rd;
                n_wait_head           = r_wait_head + WIDX_W'(1);
                n_waiters             = r_waiters - CNT_W'(1);
            end else begin
                n_out.event_res = EV_FREED;
                // Drop returns when nothing is outstanding.
                if (r_busy != '0 && r_free_count < CNT_W'(POOL_DEPTH)) begin
                    free_ctl.wr_en = exec_go;
                    n_free_count   = r_free_count + CNT_W'(1);
                    n_busy         = r_busy - CNT_W'(1);
                end
            end
        end

        n_out.busy_entries = n_busy;
        n_out.pool_busy    = (n_busy != '0);
        n_out.waiter_count = n_waiters;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_take) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (exec_go) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    bpwq_free_list u_free_list (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (free_ctl),
        .o_rd_data (free_rd)
    );

    bpwq_ram #(
        .WIDTH (REQ_W),
        .DEPTH (WAIT_DEPTH)
    ) u_wait_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wait_wr_en),
        .i_wr_addr (r_wait_tail),
        .i_wr_data (r_item.requester_id),
        .i_rd_addr (r_wait_head),
        .o_rd_data (wait_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_out_valid  <= 1'b0;
            r_free_head  <= '0;
            r_free_count <= CNT_W'(POOL_DEPTH);
            r_wait_head  <= '0;
            r_wait_tail  <= '0;
            r_waiters    <= '0;
            r_busy       <= '0;
        end else begin
            r_state <= n_state;
            if (exec_go) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (cfg_take) begin
                // Refill: free list 0..size-1, queue empty.
                r_free_head  <= '0;
                r_free_count <= cfg_size;
                r_wait_head  <= '0;
                r_wait_tail  <= '0;
                r_waiters    <= '0;
                r_busy       <= '0;
            end else if (exec_go) begin
                r_free_head  <= n_free_head;
                r_free_count <= n_free_count;
                r_wait_head  <= n_wait_head;
                r_wait_tail  <= n_wait_tail;
                r_waiters    <= n_waiters;
                r_busy       <= n_busy;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_item <= i_in_word;
        end
        if (exec_go) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // Free entries plus outstanding entries never exceed the pool.
    a_pool_conserved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_free_count} + {1'b0, r_busy}) <= (CNT_W+1)'(POOL_DEPTH))
        else $error("free plus busy exceeds pool depth");

    // Requesters wait only while the free list is empty.
    a_wait_means_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_waiters != '0) |-> (r_free_count == '0))
        else $error("waiters present with free entries");

    a_wait_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_waiters <= CNT_W'(WAIT_DEPTH))
        else $error("wait queue count overflow");

    // Each finished request leaves a result word pending.
    a_exec_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        exec_go |=> o_out_valid)
        else $error("finished request left no result");

    a_take_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> (r_state == ST_EXEC))
        else $error("accepted request not in execution");

endmodule

/* bench/pool_ledger_pkg.sv */
`timescale 1ns / 1ps

package pool_ledger_pkg;

    import bpwq_pkg::*;

    localparam logic REQ_ACQUIRE = 1'b0;
    localparam logic REQ_RETURN  = 1'b1;

    // Track the pool as the block should see it and hold the result words still owed.
    class pool_ledger;

        int unsigned size_now;
        int unsigned errors;

        logic [PIDX_W-1:0] free_list [POOL_DEPTH];
        logic [PIDX_W-1:0] free_head;
        logic [CNT_W-1:0]  free_count;
        logic [REQ_W-1:0]  waiter_ids [WAIT_DEPTH];
        logic [WIDX_W-1:0] waiter_head;
        logic [WIDX_W-1:0] waiter_tail;
        logic [CNT_W-1:0]  waiters_held;
        logic [CNT_W-1:0]  busy_total;

        t_out_word due_words [$];

        function new();
            errors = 0;
            set_capacity(CNT_W'(16));
        endfunction

        // Clamp the size, then refill the free list in index order and empty the queue.
        function void set_capacity(logic [CNT_W-1:0] value);
            int unsigned n;
            n = value;
            if (n == 0) n = 1;
            if (n > POOL_DEPTH) n = POOL_DEPTH;
            size_now = n;
            for (int i = 0; i < POOL_DEPTH; i++) begin
                free_list[i] = (i < n) ? PIDX_W'(i) : '0;
            end
            for (int i = 0; i < WAIT_DEPTH; i++) begin
                waiter_ids[i] = '0;
            end
            free_head    = '0;
            free_count   = CNT_W'(n);
            waiter_head  = '0;
            waiter_tail  = '0;
            waiters_held = '0;
            busy_total   = '0;
        endfunction

        function int unsigned pending();
            return due_words.size();
        endfunction

        // Advance the pool state for one accepted request and queue its result word.
        function void note_request(t_in_word req);
            t_out_word         want;
            logic [PIDX_W-1:0] slot;
            want = '0;
            if (req.req_type == REQ_ACQUIRE) begin
                if (free_count != 0) begin
                    want.grant_entry     = free_list[free_head];
                    want.grant_requester = req.requester_id;
                    free_head++;
                    free_count--;
                    busy_total++;
                    want.event_res = EV_GRANT;
                end else if (waiters_held < WAIT_DEPTH) begin
                    waiter_ids[waiter_tail] = req.requester_id;
                    waiter_tail++;
                    waiters_held++;
                    want.event_res = EV_QUEUED;
                end else begin
                    want.event_res = EV_FULL;
                end
            end else begin
                if (waiters_held != 0) begin
                    want.grant_requester = waiter_ids[waiter_head];
                    want.grant_entry     = req.entry_index;
                    waiter_head++;
                    waiters_held--;
                    want.event_res = EV_HANDOFF;
                end else begin
                    // A return with nothing outstanding leaves the state alone.
                    if (busy_total != 0 && free_count < POOL_DEPTH) begin
                        slot = free_head + free_count[PIDX_W-1:0];
                        free_list[slot] = req.entry_index;
                        free_count++;
                        busy_total--;
                    end
                    want.event_res = EV_FREED;
                end
            end
            want.busy_entries = busy_total;
            want.pool_busy    = (busy_total != 0);
            want.waiter_count = waiters_held;
            due_words.push_back(want);
        endfunction

        task report(string what, int got, int want);
            errors++;
            if (errors <= 40) begin
                $display("%0d ns: %s mismatch, got %0d, expected %0d", $time, what, got, want);
            end
        endtask

        task check_result(t_out_word got);
            t_out_word want;
            if (due_words.size() == 0) begin
                report("unexpected result word, event_res", got.event_res, -1);
                return;
            end
            want = due_words.pop_front();
            if (got.event_res != want.event_res)
                report("event_res", got.event_res, want.event_res);
            if (got.grant_requester != want.grant_requester)
                report("grant_requester", got.grant_requester, want.grant_requester);
            if (got.grant_entry != want.grant_entry)
                report("grant_entry", got.grant_entry, want.grant_entry);
            if (got.busy_entries != want.busy_entries)
                report("busy_entries", got.busy_entries, want.busy_entries);
            if (got.pool_busy != want.pool_busy)
                report("pool_busy", got.pool_busy, want.pool_busy);
            if (got.waiter_count != want.waiter_count)
                report("waiter_count", got.waiter_count, want.waiter_count);
        endtask

    endclass

endpackage

/* bench/buffer_pool_with_wait_queue_core_tb.sv */
`timescale 1ns / 1ps

module buffer_pool_with_wait_queue_core_tb;

    import bpwq_pkg::*;
    import pool_ledger_pkg::*;

    localparam int ITEM_TARGET = 1100;
    localparam int CYCLE_LIMIT = 200000;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_stall;
    t_in_word         i_in_word;
    logic             o_out_valid;
    logic             i_out_stall;
    t_out_word        o_out_word;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [CNT_W-1:0] i_cfg_data;

    pool_ledger ledger;

    // Idle odds in percent for each side, and the receiver's long hold-off.
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned hold_left;
    int unsigned cycle_count;

    buffer_pool_with_wait_queue_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Drive the receiver's stall at each falling edge. A pending hold-off wins over
    // the random odds and is counted down here.
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_out_stall = 1'b1;
                hold_left--;
            end else begin
                i_out_stall = ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    // Check every result word taken at a rising edge against the oldest one owed.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            ledger.check_result(o_out_word);
        end
    end

    // Stop a hung run.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // All driving tasks start and end at a rising edge; inputs change at falling edges.

    // Offer one request word, idling first at the sender's odds, and hold it until taken.
    task automatic send_request(t_in_word req);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_word  = req;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        ledger.note_request(req);
    endtask

    task automatic send_acquire(logic [REQ_W-1:0] id);
        t_in_word req;
        req              = '0;
        req.req_type     = REQ_ACQUIRE;
        req.requester_id = id;
        req.entry_index  = PIDX_W'($urandom_range(15));
        send_request(req);
    endtask

    task automatic send_return(logic [PIDX_W-1:0] idx);
        t_in_word req;
        req              = '0;
        req.req_type     = REQ_RETURN;
        req.requester_id = REQ_W'($urandom_range(255));
        req.entry_index  = idx;
        send_request(req);
    endtask

    // Drop valid and wait until every owed result word has come back.
    task automatic wait_for_results();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        @(posedge i_clk);
        while (ledger.pending() > 0) @(posedge i_clk);
    endtask

    // Write the capacity only with the block idle; the write also refills the pool.
    task automatic write_capacity(logic [CNT_W-1:0] value);
        wait_for_results();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        ledger.set_capacity(value);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        int unsigned      sent;
        int unsigned      seg;
        int unsigned      seg_len;
        int unsigned      acq_pct;
        logic [CNT_W-1:0] new_size;
        logic [PIDX_W-1:0] idx;

        ledger        = new();
        send_idle_pct = 8;
        recv_idle_pct = 55;
        hold_left     = 0;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in_word     = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(posedge i_clk);

        // Directed part. Return with nothing outstanding first: ignored, reports freed.
        send_return(4'hF);
        send_acquire(8'hFF);
        send_acquire(8'h00);
        send_return(4'h0);

        // A size of zero is taken as one. Take the only entry, fill the wait queue,
        // overflow it once, then hand two entries to the oldest waiters.
        write_capacity(5'd0);
        send_acquire(8'hAA);
        for (int i = 0; i < WAIT_DEPTH; i++) begin
            send_acquire(REQ_W'(8'h55 ^ i));
        end
        send_acquire(8'h01);
        send_return(4'hF);
        send_return(4'h0);

        // Oversized write clamps to the full pool depth.
        write_capacity(5'd31);

        // Random part in segments, each with its own acquire mix.
        sent = 0;
        seg  = 0;
        while (sent < ITEM_TARGET) begin
            if (sent < ITEM_TARGET / 3) begin
                send_idle_pct = 8;
                recv_idle_pct = 55;
            end else if (sent < 2 * ITEM_TARGET / 3) begin
                send_idle_pct = 55;
                recv_idle_pct = 8;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            // Reconfigure now and then, mostly to small pools so the wait queue fills.
            if ($urandom_range(3) == 0) begin
                case ($urandom_range(7))
                    5:       new_size = 5'd0;
                    6:       new_size = 5'd31;
                    7:       new_size = CNT_W'($urandom_range(5, 31));
                    default: new_size = CNT_W'($urandom_range(1, 4));
                endcase
                write_capacity(new_size);
            end

            // Hold the receiver off for a long stretch while requests keep coming.
            if (seg % 6 == 2) hold_left = 80;
            // Pause the sender until the block has answered everything.
            if (seg % 9 == 5) wait_for_results();

            case ($urandom_range(4))
                0:       acq_pct = 15;
                1, 2:    acq_pct = 50;
                3:       acq_pct = 75;
                default: acq_pct = 95;
            endcase
            seg_len = $urandom_range(20, 60);

            for (int k = 0; k < seg_len; k++) begin
                if ($urandom_range(99) < acq_pct) begin
                    send_acquire(REQ_W'($urandom_range(255)));
                end else begin
                    // Mostly return an entry inside the pool; sometimes any index.
                    if ($urandom_range(9) < 7)
                        idx = PIDX_W'($urandom_range(ledger.size_now - 1));
                    else
                        idx = PIDX_W'($urandom_range(15));
                    send_return(idx);
                end
                sent++;
            end
            seg++;
        end

        wait_for_results();
        repeat (4) @(posedge i_clk);
        if (ledger.errors == 0 && ledger.pending() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/core/bpwq_pkg.sv
rtl/core/bpwq_ram.sv
rtl/core/bpwq_free_list.sv
rtl/core/buffer_pool_with_wait_queue_core.sv
bench/pool_ledger_pkg.sv
bench/buffer_pool_with_wait_queue_core_tb.sv
